[src/array_list_record_engine_core_assert.svh]
`ifndef ARRAY_LIST_RECORD_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_RECORD_ENGINE_CORE_ASSERT_SVH
// Assertion helpers shared by the checker.
`define ALRE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ALRE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/alre_pkg.sv]
package alre_pkg;
    localparam logic [3:0] ACT_CLEAR    = 4'd0;
    localparam logic [3:0] ACT_INS_FRONT = 4'd1;
    localparam logic [3:0] ACT_INS_BACK = 4'd2;
    localparam logic [3:0] ACT_INS_POS  = 4'd3;
    localparam logic [3:0] ACT_RM_FRONT = 4'd4;
    localparam logic [3:0] ACT_RM_BACK  = 4'd5;
    localparam logic [3:0] ACT_RM_POS   = 4'd6;
    localparam logic [3:0] ACT_RM_KEY   = 4'd7;
    localparam logic [3:0] ACT_FIND     = 4'd8;
    localparam logic [3:0] ACT_READ     = 4'd9;
    localparam logic [3:0] ACT_COUNT    = 4'd10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam int REC_W = 128;

    typedef struct packed {
        logic [63:0] name;
        logic [31:0] score;
        logic [31:0] key;
    } rec_t;
endpackage

[src/array_list_record_engine_core.sv]
// Find, count and remove-by-key walk the whole list; insert and remove at a position walk
// from pos to the end of the list (pos 0 at the front). One operation is in flight at a time:
// s_tready stays low until the result has been taken, so each m_tready stall also holds off
// the next input transfer.
// Reset (aresetn low, synchronous) empties the list; record memory is not cleared.
module array_list_record_engine_core #(
    parameter int CAPACITY   = 128,
    parameter int NAME_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: action[3:0], item_key[35:4], item_score[67:36],
    // item_name[131:68], position[139:132], zero fill to 144
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: status[2:0], found_key[34:3], found_score[66:35],
    // found_name[130:67], match_count[138:131], list_length[146:139], zero fill
    output logic [151:0] m_tdata
);
    import alre_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_WAIT  = 5'b00100,
        S_DONE  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]  act_reg;
    rec_t        item_reg;
    logic [CW-1:0] pos_reg;
    // walk: read index, write index
    logic [CW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic        rvalid_reg, rvalid_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    rec_t        carry_reg, carry_next;
    logic [2:0]  st_reg, st_next;
    rec_t        fnd_reg, fnd_next;
    logic [CW-1:0] mc_reg, mc_next;
    logic        mvalid_reg;
    logic [151:0] mdata_reg;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    rec_t        wdata, rdata;

    alre_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Normalize: keep bytes up to the first zero, within NAME_BYTES.
    function automatic logic [63:0] norm_name(input logic [63:0] n);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= NAME_BYTES || n[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*i +: 8] = n[8*i +: 8];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    logic accept;
    assign accept = s_tvalid && s_tready;

    logic [7:0] in_pos;
    assign in_pos = s_tdata[139:132];

    // Saturate a position that does not fit the index width; it is past the end anyway.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg        <= s_tdata[3:0];
            item_reg.key   <= s_tdata[35:4];
            item_reg.score <= s_tdata[67:36];
            item_reg.name  <= norm_name(s_tdata[131:68]);
            pos_reg        <= (|(in_pos >> CW)) ? '1 : CW'(in_pos);
        end
    end

    // Combinational control of the walk.
    logic rd_go;
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        rvalid_next = 1'b0;
        ridx_next   = rd_reg;
        carry_next  = carry_reg;
        st_next     = st_reg;
        fnd_next    = fnd_reg;
        mc_next     = mc_reg;
        we          = 1'b0;
        waddr       = wr_reg[AW-1:0];
        wdata       = rdata;
        raddr       = rd_reg[AW-1:0];
        rd_go       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                // set up the operation
                st_next  = ST_OK;
                fnd_next = '0;
                mc_next  = '0;
                state_next = S_DONE;
                rd_next  = '0;
                wr_next  = '0;
                if ((act_reg == ACT_INS_FRONT || act_reg == ACT_INS_BACK ||
                     act_reg == ACT_INS_POS) && count_reg >= CW'(CAPACITY)) begin
                    st_next = ST_FULL;
                end else if (act_reg >= ACT_RM_FRONT && act_reg <= ACT_COUNT &&
                             count_reg == '0) begin
                    st_next = ST_EMPTY;
                end else begin
                    case (act_reg)
                        ACT_CLEAR: count_next = '0;
                        ACT_INS_BACK: begin
                            we = 1'b1; waddr = count_reg[AW-1:0]; wdata = item_reg;
                            count_next = count_reg + 1'b1;
                        end
                        ACT_INS_FRONT, ACT_INS_POS: begin
                            if (act_reg == ACT_INS_POS && pos_reg > count_reg) begin
                                st_next = ST_BADPOS;
                            end else begin
                                // insert-walk: write item at pos, then carry up
                                wr_next = (act_reg == ACT_INS_FRONT) ? '0 : pos_reg;
                                rd_next = wr_next;
                                carry_next = item_reg;
                                state_next = S_WAIT;
                            end
                        end
                        ACT_RM_BACK: count_next = count_reg - 1'b1;
                        ACT_RM_FRONT, ACT_RM_POS: begin
                            if (act_reg == ACT_RM_POS && pos_reg >= count_reg) begin
                                st_next = ST_BADPOS;
                            end else begin
                                wr_next = (act_reg == ACT_RM_FRONT) ? '0 : pos_reg;
                                rd_next = wr_next + 1'b1;
                                state_next = S_WAIT;
                            end
                        end
                        ACT_RM_KEY, ACT_FIND, ACT_COUNT: begin
                            if (act_reg == ACT_FIND) st_next = ST_NOTFOUND;
                            state_next = S_WAIT;
                        end
                        ACT_READ: begin
                            if (pos_reg >= count_reg) begin
                                st_next = ST_BADPOS;
                            end else begin
                                rd_next = pos_reg;
                                state_next = S_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT: begin
                // issue reads at rd_reg while in range; process returned data
                if (rd_reg < count_reg && !(act_reg == ACT_READ && rvalid_reg)) begin
                    rd_go       = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_reg;
                    rd_next     = rd_reg + 1'b1;
                end
                if (rvalid_reg) begin
                    case (act_reg)
                        ACT_INS_FRONT, ACT_INS_POS: begin
                            we = 1'b1; waddr = ridx_reg[AW-1:0]; wdata = carry_reg;
                            carry_next = rdata;
                        end
                        ACT_RM_FRONT, ACT_RM_POS: begin
                            we = 1'b1; waddr = wr_reg[AW-1:0]; wdata = rdata;
                            wr_next = wr_reg + 1'b1;
                        end
                        ACT_RM_KEY: begin
                            if (rdata.key != item_reg.key) begin
                                we = 1'b1; waddr = wr_reg[AW-1:0]; wdata = rdata;
                                wr_next = wr_reg + 1'b1;
                            end
                        end
                        ACT_FIND: begin
                            if (rdata.key == item_reg.key && st_reg == ST_NOTFOUND) begin
                                st_next  = ST_OK;
                                fnd_next = rdata;
                            end
                        end
                        ACT_READ: fnd_next = rdata;
                        ACT_COUNT: begin
                            if (rdata == item_reg) mc_next = mc_reg + 1'b1;
                        end
                        default: ;
                    endcase
                end
                // last data consumed this cycle (or none pending)
                if (!rd_go) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // finish: tail writes and length updates
                case (act_reg)
                    ACT_INS_FRONT, ACT_INS_POS: begin
                        if (st_reg == ST_OK) begin
                            we = 1'b1; waddr = count_reg[AW-1:0]; wdata = carry_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_RM_FRONT, ACT_RM_POS: begin
                        if (st_reg == ST_OK) count_next = count_reg - 1'b1;
                    end
                    ACT_RM_KEY: begin
                        if (st_reg == ST_OK) count_next = wr_reg;
                    end
                    default: ;
                endcase
                state_next = S_OUT;
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // In insert walks the carried record at the current count goes in S_DONE; the
    // walk writes carry into each slot as its old value is read back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            if (state_reg == S_OUT) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        ridx_reg  <= ridx_next;
        carry_reg <= carry_next;
        st_reg    <= st_next;
        fnd_reg   <= fnd_next;
        mc_reg    <= mc_next;
        if (state_reg == S_OUT) begin
            mdata_reg <= {5'd0, 8'(count_reg), 8'(mc_reg), fnd_reg.name,
                          fnd_reg.score, fnd_reg.key, st_reg};
        end
    end
endmodule

[src/alre_ram.sv]
module alre_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/alre_checker.sv]
`include "array_list_record_engine_core_assert.svh"
module alre_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);
    `ALRE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `ALRE_ASSERT_IMPL(a_busy, aclk, aresetn, m_tvalid, !s_tready, "accepted while result pending")
    `ALRE_ASSERT_IMPL(a_stat, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4, "status code out of range")
    `ALRE_ASSERT_NEXT(a_one, aclk, aresetn, s_tvalid && s_tready, !m_tvalid, "result too early")
endmodule

bind array_list_record_engine_core alre_checker u_alre_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[verif/array_list_record_engine_core_checker.sv]
`timescale 1ns / 1ps
module array_list_record_engine_core_checker
    import alre_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int NAME_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [151:0] m_tdata,
    output int           err_count,
    output int           pending
);
    typedef struct packed {
        logic [7:0]  list_length;
        logic [7:0]  match_count;
        logic [63:0] found_name;
        logic [31:0] found_score;
        logic [31:0] found_key;
        logic [2:0]  status;
    } reply_t;

    rec_t   list_q[$];
    reply_t replies_due[$];

    assign pending = replies_due.size();

    function automatic logic [63:0] trim_name(logic [63:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < NAME_BYTES && i < 8; i++) begin
            if (n[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = n[8*i +: 8];
        end
        return r;
    endfunction

    function automatic reply_t apply_op(logic [143:0] d);
        reply_t r;
        rec_t   rec;
        logic [3:0] act;
        int pos, i, n;
        act = d[3:0];
        rec.key = d[35:4];
        rec.score = d[67:36];
        rec.name = trim_name(d[131:68]);
        pos = int'(d[139:132]);
        r = '0;
        r.status = ST_OK;
        n = list_q.size();
        if (act >= ACT_INS_FRONT && act <= ACT_INS_POS && n >= CAPACITY) begin
            r.status = ST_FULL;
        end else if (act >= ACT_RM_FRONT && act <= ACT_COUNT && n == 0) begin
            r.status = ST_EMPTY;
        end else begin
            case (act)
                ACT_CLEAR:     list_q.delete();
                ACT_INS_FRONT: list_q.push_front(rec);
                ACT_INS_BACK:  list_q.push_back(rec);
                ACT_INS_POS: begin
                    if (pos > n) r.status = ST_BADPOS;
                    else list_q.insert(pos, rec);
                end
                ACT_RM_FRONT:  void'(list_q.pop_front());
                ACT_RM_BACK:   void'(list_q.pop_back());
                ACT_RM_POS: begin
                    if (pos >= n) r.status = ST_BADPOS;
                    else list_q.delete(pos);
                end
                ACT_RM_KEY: begin
                    i = 0;
                    while (i < list_q.size()) begin
                        if (list_q[i].key == rec.key) list_q.delete(i);
                        else i++;
                    end
                end
                ACT_FIND: begin
                    r.status = ST_NOTFOUND;
                    foreach (list_q[j]) begin
                        if (list_q[j].key == rec.key) begin
                            r.status = ST_OK;
                            r.found_key = list_q[j].key;
                            r.found_score = list_q[j].score;
                            r.found_name = list_q[j].name;
                            break;
                        end
                    end
                end
                ACT_READ: begin
                    if (pos >= n) r.status = ST_BADPOS;
                    else begin
                        r.found_key = list_q[pos].key;
                        r.found_score = list_q[pos].score;
                        r.found_name = list_q[pos].name;
                    end
                end
                ACT_COUNT: begin
                    foreach (list_q[j])
                        if (list_q[j] == rec) r.match_count++;
                end
                default: ;
            endcase
        end
        r.list_length = 8'(list_q.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want, got;
        if (!aresetn) begin
            list_q.delete();
            replies_due.delete();
            err_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[146:0];
                if (replies_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_count <= err_count + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (got != want) begin
                        err_count <= err_count + 1;
                        if (got.status != want.status)
                            $error("status exp %0d got %0d", want.status, got.status);
                        if (got.found_key != want.found_key)
                            $error("found_key exp %h got %h", want.found_key, got.found_key);
                        if (got.found_score != want.found_score)
                            $error("found_score exp %h got %h", want.found_score,
                                   got.found_score);
                        if (got.found_name != want.found_name)
                            $error("found_name exp %h got %h", want.found_name,
                                   got.found_name);
                        if (got.match_count != want.match_count)
                            $error("match_count exp %0d got %0d", want.match_count,
                                   got.match_count);
                        if (got.list_length != want.list_length)
                            $error("list_length exp %0d got %0d", want.list_length,
                                   got.list_length);
                    end
                end
            end
            if (s_tvalid && s_tready) replies_due.push_back(apply_op(s_tdata));
        end
    end
endmodule

[verif/tb_array_list_record_engine_core.sv]
`timescale 1ns / 1ps
module tb_array_list_record_engine_core;
    import alre_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    int           err_count;
    int           pending;

    // Idle percentages per side; the stimulus process switches phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;

    // Key pool kept small so finds, counts and remove-by-key hit often.
    logic [31:0] key_pool [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    array_list_record_engine_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    array_list_record_engine_core_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .err_count(err_count), .pending(pending)
    );

    // Drive the receiver ready; a hold-off forces it low.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [143:0] pack_op(logic [3:0] act, logic [31:0] key,
                                             logic [31:0] score, logic [63:0] name,
                                             logic [7:0] pos);
        return {4'd0, pos, name, score, key, act};
    endfunction

    // Present one item, wait for its transfer; tvalid stays high into the next item unless an idle gap drops it.
    task automatic send_op(logic [143:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(int n_items);
        logic [3:0]  act;
        logic [31:0] key;
        logic [63:0] name;
        logic [7:0]  pos;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(9))
                0, 1, 2: act = $urandom_range(ACT_INS_POS, ACT_INS_FRONT);
                3:       act = (i % 97 == 0) ? ACT_CLEAR : $urandom_range(15);
                default: act = $urandom_range(ACT_COUNT, ACT_RM_FRONT);
            endcase
            key  = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(3)];
            name = {$urandom, $urandom};
            if ($urandom_range(1)) name[8*$urandom_range(7) +: 8] = 8'd0;
            pos  = ($urandom_range(4) == 0) ? $urandom : $urandom_range(pending + 4);
            send_op(pack_op(act, key, ($urandom_range(3) == 0) ? 32'h3f80_0000 : $urandom,
                            name, pos));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        #60_000_000;
        $display("tb_array_list_record_engine_core: errors");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, extremes, every action, bad positions, unused codes.
        send_op(pack_op(ACT_RM_FRONT, 0, 0, 0, 0));
        send_op(pack_op(ACT_FIND, 0, 0, 0, 0));
        send_op(pack_op(ACT_COUNT, 0, 0, 0, 0));
        send_op(pack_op(ACT_INS_FRONT, 32'h8000_0000, '1, '1, 0));
        send_op(pack_op(ACT_INS_BACK, 32'h7fff_ffff, 0, 64'h00ff_0041, 0));
        send_op(pack_op(ACT_INS_POS, 5, 32'h3f80_0000, 64'h4142, 1));
        send_op(pack_op(ACT_INS_POS, 6, 1, 1, 3));
        send_op(pack_op(ACT_INS_POS, 7, 1, 1, 8'hff));
        send_op(pack_op(ACT_READ, 0, 0, 0, 3));
        send_op(pack_op(ACT_READ, 0, 0, 0, 4));
        send_op(pack_op(ACT_READ, 0, 0, 0, 8'hff));
        send_op(pack_op(ACT_COUNT, 32'h7fff_ffff, 0, 64'h1200_0041, 0));
        send_op(pack_op(ACT_FIND, 5, 0, 0, 0));
        send_op(pack_op(ACT_FIND, 99, 0, 0, 0));
        send_op(pack_op(ACT_RM_POS, 0, 0, 0, 4));
        send_op(pack_op(ACT_RM_POS, 0, 0, 0, 1));
        send_op(pack_op(ACT_INS_BACK, 6, 2, 2, 0));
        send_op(pack_op(ACT_RM_KEY, 6, 0, 0, 0));
        send_op(pack_op(ACT_RM_KEY, 42, 0, 0, 0));
        send_op(pack_op(ACT_RM_BACK, 0, 0, 0, 0));
        send_op(pack_op(4'd11, 0, 0, 0, 0));
        send_op(pack_op(4'd15, '1, '1, '1, '1));
        send_op(pack_op(ACT_CLEAR, 0, 0, 0, 0));
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Fill to capacity and beyond to hit the full-list case.
        for (int i = 0; i < 130; i++)
            send_op(pack_op(ACT_INS_BACK, key_pool[i % 4], i, i, 0));
        send_op(pack_op(ACT_INS_POS, 1, 1, 1, 128));
        send_op(pack_op(ACT_READ, 0, 0, 0, 127));
        send_op(pack_op(ACT_RM_KEY, 32'd0, 0, 0, 0));
        send_op(pack_op(ACT_CLEAR, 0, 0, 0, 0));
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(30);
        join

        send_idle_pct = 0;  recv_idle_pct = 0;  send_random(115);
        send_idle_pct = 87; recv_idle_pct = 0;  send_random(115);
        send_idle_pct = 0;  recv_idle_pct = 87; send_random(115);
        send_idle_pct = 19; recv_idle_pct = 19; send_random(120);

        drain();
        if (err_count == 0) begin
            $display("tb_array_list_record_engine_core: clean");
        end else begin
            $display("tb_array_list_record_engine_core: errors");
        end
        $finish;
    end
endmodule
